/* sv/lslc_pkg.sv */
package lslc_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DEADBAND      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VEL_THRESHOLD = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CUR_THRESHOLD = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STALL_TIME    = 8'd3;

   // register reset values
   localparam logic [6:0]  DEADBAND_RST      = 7'd10;
   localparam logic [9:0]  VEL_THRESHOLD_RST = 10'd5;
   localparam logic [15:0] CUR_THRESHOLD_RST = 16'd2500;
   localparam logic [15:0] STALL_TIME_RST    = 16'd50;

   // lockout direction codes
   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // live configuration
   typedef struct packed {
      logic [6:0]  deadband;
      logic [9:0]  velocity_threshold;
      logic [15:0] current_threshold;
      logic [15:0] stall_time_ms;
   } cfg_type;

endpackage

/* sv/lslc_req_if.sv */
interface lslc_req_if;
   logic               valid;
   logic               ready;
   logic               enable;
   logic signed [7:0]  stick;
   logic [31:0]        now_ms;
   logic signed [10:0] velocity_a;
   logic signed [10:0] velocity_b;
   logic [15:0]        current_a;
   logic [15:0]        current_b;
   logic signed [31:0] position_a;
   logic signed [31:0] position_b;

   modport source (
      output valid, enable, stick, now_ms, velocity_a, velocity_b,
             current_a, current_b, position_a, position_b,
      input  ready
   );
   modport sink (
      input  valid, enable, stick, now_ms, velocity_a, velocity_b,
             current_a, current_b, position_a, position_b,
      output ready
   );
endinterface

/* sv/lslc_rsp_if.sv */
interface lslc_rsp_if;
   logic               valid;
   logic               ready;
   logic               hold_mode;
   logic signed [7:0]  drive_value;
   logic signed [31:0] hold_target;
   logic [1:0]         lockout_direction;

   modport source (
      output valid, hold_mode, drive_value, hold_target, lockout_direction,
      input  ready
   );
   modport sink (
      input  valid, hold_mode, drive_value, hold_target, lockout_direction,
      output ready
   );
endinterface

/* sv/lift_stall_lockout_control_core.sv */
// Lift stall lockout control core.
// Each accepted request's response is held in the output register, valid in the cycle after acceptance.
// One transaction per clock while responses are taken; the lockout/timer state updates on each accepted request.
// The output register accepts a new request while its response is taken.
// Synchronous active-high reset: registers to defaults, lockout none, timer idle,
// held position zero, no response pending.
module lift_stall_lockout_control_core (
   input  logic                              clock,
   input  logic                              reset,
   lslc_req_if.sink                          req_if,
   lslc_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [lslc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lslc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lslc_pkg::*;

   cfg_type            cfg_ff;
   dir_type            locked_dir_ff, locked_dir_in, dir_mid;
   logic               stall_timing_ff, stall_timing_in;
   logic [31:0]        stall_start_ff, stall_start_in;
   logic signed [31:0] held_pos_ff, held_pos_in;

   logic               rsp_valid_ff;
   logic               hold_mode_ff, hold_mode_in;
   logic signed [7:0]  drive_ff, drive_in;
   logic signed [31:0] target_ff;
   dir_type            lockout_ff;

   logic               accept;
   logic               stall_a, stall_b, stalled;
   logic [7:0]         stick_mag;
   logic signed [7:0]  y;
   logic               blocked, expired;
   logic [31:0]        elapsed;
   logic signed [32:0] pos_sum;
   logic signed [31:0] pos_avg;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband           <= DEADBAND_RST;
         cfg_ff.velocity_threshold <= VEL_THRESHOLD_RST;
         cfg_ff.current_threshold  <= CUR_THRESHOLD_RST;
         cfg_ff.stall_time_ms      <= STALL_TIME_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEADBAND:      cfg_ff.deadband           <= csr_wdata[6:0];
            REG_VEL_THRESHOLD: cfg_ff.velocity_threshold <= csr_wdata[9:0];
            REG_CUR_THRESHOLD: cfg_ff.current_threshold  <= csr_wdata[15:0];
            REG_STALL_TIME:    cfg_ff.stall_time_ms      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // one stall detector lane per motor
   lslc_motor_lane u_lane_a (
      .cfg      (cfg_ff),
      .velocity (req_if.velocity_a),
      .current  (req_if.current_a),
      .stalled  (stall_a)
   );

   lslc_motor_lane u_lane_b (
      .cfg      (cfg_ff),
      .velocity (req_if.velocity_b),
      .current  (req_if.current_b),
      .stalled  (stall_b)
   );

   // merge lane results
   assign stalled = stall_a | stall_b;

   // handshake: output register frees up when empty or being drained
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // deadband on the stick
   assign stick_mag = req_if.stick[7] ? 8'(-req_if.stick) : 8'(req_if.stick);
   assign y = (stick_mag < {1'b0, cfg_ff.deadband}) ? 8'sd0 : req_if.stick;

   // floored average of both positions, 33-bit sum
   assign pos_sum = 33'(req_if.position_a) + 33'(req_if.position_b);
   assign pos_avg = pos_sum[32:1];

   // elapsed stall time; a fresh stall starts at zero
   assign elapsed = stall_timing_ff ? (req_if.now_ms - stall_start_ff) : 32'd0;
   assign expired = stalled && (elapsed > {16'd0, cfg_ff.stall_time_ms});

   // lockout release, then block check
   always_comb begin
      dir_mid = locked_dir_ff;
      if ((locked_dir_ff == DIR_UP && y <= 8'sd0) ||
          (locked_dir_ff == DIR_DOWN && y >= 8'sd0))
         dir_mid = DIR_NONE;
      blocked = (dir_mid == DIR_UP && y > 8'sd0) ||
                (dir_mid == DIR_DOWN && y < 8'sd0);
   end

   // next state and response
   always_comb begin
      locked_dir_in   = locked_dir_ff;
      stall_timing_in = stall_timing_ff;
      stall_start_in  = stall_start_ff;
      held_pos_in     = held_pos_ff;
      hold_mode_in    = 1'b0;
      drive_in        = 8'sd0;
      if (!req_if.enable) begin
         hold_mode_in    = 1'b1;
         stall_timing_in = 1'b0;
      end else if (blocked) begin
         locked_dir_in = dir_mid;
      end else begin
         locked_dir_in = dir_mid;
         if (stalled) begin
            stall_timing_in = 1'b1;
            if (!stall_timing_ff)
               stall_start_in = req_if.now_ms;
         end else begin
            stall_timing_in = 1'b0;
         end
         if (expired) begin
            locked_dir_in = (y > 8'sd0) ? DIR_UP : DIR_DOWN;
         end else begin
            drive_in    = y;
            held_pos_in = pos_avg;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         locked_dir_ff   <= DIR_NONE;
         stall_timing_ff <= 1'b0;
         stall_start_ff  <= 32'd0;
         held_pos_ff     <= 32'sd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            locked_dir_ff   <= locked_dir_in;
            stall_timing_ff <= stall_timing_in;
            stall_start_ff  <= stall_start_in;
            held_pos_ff     <= held_pos_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_mode_ff <= hold_mode_in;
         drive_ff     <= drive_in;
         target_ff    <= held_pos_in;
         lockout_ff   <= locked_dir_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.hold_mode         = hold_mode_ff;
   assign rsp_if.drive_value       = drive_ff;
   assign rsp_if.hold_target       = target_ff;
   assign rsp_if.lockout_direction = lockout_ff;

   // hold transactions give a hold response with zero drive
   a_hold_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_if.enable) |=>
         (rsp_if.valid && rsp_if.hold_mode && rsp_if.drive_value == 8'sd0))
      else $error("hold transaction did not yield a zero-drive hold response");

   // enable low stops stall timing and keeps the held position
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_if.enable) |=>
         (!stall_timing_ff && held_pos_ff == $past(held_pos_ff)))
      else $error("hold transaction changed the held position or kept timing");

   // a newly set lockout always drives zero
   a_lock_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.enable && locked_dir_in != DIR_NONE &&
       locked_dir_in != locked_dir_ff) |=> (rsp_if.drive_value == 8'sd0))
      else $error("lockout set with nonzero drive");

   // response carries the lockout state that was stored
   a_lock_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_if.lockout_direction == locked_dir_ff &&
                  rsp_if.hold_target == held_pos_ff))
      else $error("response disagrees with stored state");
endmodule

/* sv/lslc_motor_lane.sv */
module lslc_motor_lane (
   input  lslc_pkg::cfg_type  cfg,
   input  logic signed [10:0] velocity,
   input  logic [15:0]        current,
   output logic               stalled
);
   import lslc_pkg::*;

   logic [10:0] speed_mag;

   // speed magnitude; -1024 gives 1024, which fits unsigned 11 bits
   assign speed_mag = velocity[10] ? 11'(-velocity) : 11'(velocity);

   // stall: slow and drawing high current
   assign stalled = (speed_mag < {1'b0, cfg.velocity_threshold}) &&
                    (current > cfg.current_threshold);
endmodule
